// ===== rtl/core/lpas_pkg.sv =====
// ----------------------------------------------------------------------------
// lpas_pkg: shared types and constants of the LED pattern action sequencer
// Command codes, run modes, status codes, the queued action entry and the
// pattern LFSR step.
// ----------------------------------------------------------------------------
package lpas_pkg;

  // Default number of queued actions
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  // Default random interval in ms, value after reset
  localparam logic [15:0] RAND_INTERVAL_RST = 16'd300;

  // Tags count modulo this value
  localparam logic [6:0] TAG_MODULO   = 7'd100;
  localparam logic [6:0] TAG_IDLE     = 7'd127;

  // LFSR seed and taps (Galois, right shift)
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Command codes carried in the input word's tuser
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_SET      = 3'd1;
  localparam logic [2:0] OP_BIT_ON   = 3'd2;
  localparam logic [2:0] OP_BIT_OFF  = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;
  localparam logic [2:0] OP_APPEND   = 3'd5;
  localparam logic [2:0] OP_RAND_ON  = 3'd6;
  localparam logic [2:0] OP_RAND_OFF = 3'd7;

  // Run modes
  localparam logic [1:0] MODE_FIXED  = 2'd0;
  localparam logic [1:0] MODE_ACTION = 2'd1;
  localparam logic [1:0] MODE_RANDOM = 2'd2;

  // Append status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  // One queued action
  typedef struct packed {
    logic [31:0] end_ms;
    logic [15:0] pattern;
    logic [6:0]  tag;
  } action_t;

  // One LFSR step
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/led_pattern_action_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_pattern_action_sequencer: 16-bit LED pattern driver
// Fixed, timed-action and random modes, driven by command and tick words.
// ----------------------------------------------------------------------------
// Every input word produces exactly one output word. The block takes one word
// per clock: all of a word's work is done in the cycle it is accepted, by one
// pass of logic from the state registers into the output register, so the
// rate is one word per cycle whenever the output side keeps taking words.
// The action queue (QUEUE_DEPTH entries) sits in a small memory whose
// registered read port always holds the entry behind the queue head, so a
// head drop takes its next entry straight from it. No clearing pass is needed after reset.
// The random interval register may be written at any time the block is idle.
module led_pattern_action_sequencer #(
  parameter int unsigned QUEUE_DEPTH = lpas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command / tick words
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] time_ms, [32] force_req, [40:33] byte_low, [48:41] byte_high,
  // [52:49] bit_index, [84:53] end_ms, [87:85] zero
  input  logic [87:0] in_tdata,
  // [2:0] op
  input  logic [2:0]  in_tuser,
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] drive_valid, [8:1] drive_low, [16:9] drive_high, [24:17] held_low,
  // [26:25] append_status, [31:27] zero
  output logic [31:0] out_tdata,
  // random interval register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [6:0] TAG_MODULO_M1 = lpas_pkg::TAG_MODULO - 7'd1;

  // input field unpacking
  logic [2:0]  op;
  logic [31:0] time_ms;
  logic        force_req;
  logic [7:0]  byte_low;
  logic [7:0]  byte_high;
  logic [3:0]  bit_index;
  logic [31:0] end_ms;
  logic [15:0] in_pat;
  logic [15:0] bit_mask;

  assign op        = in_tuser;
  assign time_ms   = in_tdata[31:0];
  assign force_req = in_tdata[32];
  assign byte_low  = in_tdata[40:33];
  assign byte_high = in_tdata[48:41];
  assign bit_index = in_tdata[52:49];
  assign end_ms    = in_tdata[84:53];
  assign in_pat    = {byte_high, byte_low};
  assign bit_mask  = 16'd1 << bit_index;

  // state registers
  logic [15:0]           interval_r;
  logic [15:0]           held_r,        held_nxt;
  logic [1:0]            mode_r,        mode_nxt;
  logic                  pending_r,     pending_nxt;
  logic [IW-1:0]         head_r,        head_nxt;
  logic [CW-1:0]         cnt_r,         cnt_nxt;
  logic [6:0]            run_tag_r,     run_tag_nxt;
  logic [6:0]            last_tag_r,    last_tag_nxt;
  logic [31:0]           last_rand_r,   last_rand_nxt;
  logic [1:0]            saved_mode_r,  saved_mode_nxt;
  logic [15:0]           saved_pat_r,   saved_pat_nxt;
  logic [15:0]           lfsr_r,        lfsr_nxt;
  lpas_pkg::action_t     head_act_r,    head_act_nxt;
  logic [31:0]           last_end_r,    last_end_nxt;

  // action memory and its registered read of the slot behind the head
  lpas_pkg::action_t     act_mem [QUEUE_DEPTH];
  lpas_pkg::action_t     next_act_r;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  lpas_pkg::action_t     wr_data;
  logic [IW-1:0]         rd_addr;

  // result fields
  logic                  emit;
  logic [15:0]           emit_pat;
  logic [1:0]            status;
  logic                  in_fire;
  logic                  out_valid_r;
  logic [31:0]           out_data_r;

  // helpers
  logic [IW-1:0]         head_inc;
  logic [CW:0]           tail_sum;
  logic [IW-1:0]         tail_slot;
  logic [6:0]            tag_inc;
  logic [31:0]           elapsed;
  logic [15:0]           lfsr_a;
  logic [15:0]           lfsr_b;
  lpas_pkg::action_t     new_act;
  logic [15:0]           edit_pat;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign head_inc  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_sum  = {1'b0, (CW)'(head_r)} + {1'b0, cnt_r};
  assign tail_slot = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     IW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : IW'(tail_sum);
  assign tag_inc   = (last_tag_r >= TAG_MODULO_M1) ? 7'd0 : last_tag_r + 7'd1;
  assign elapsed   = time_ms - last_rand_r;
  assign lfsr_a    = lpas_pkg::lfsr_step(lfsr_r);
  assign lfsr_b    = lpas_pkg::lfsr_step(lfsr_a);
  assign new_act   = '{end_ms: end_ms, pattern: in_pat, tag: tag_inc};

  // edited pattern for set / bit on / bit off
  always_comb begin
    unique case (op)
      lpas_pkg::OP_SET:    edit_pat = in_pat;
      lpas_pkg::OP_BIT_ON: edit_pat = held_r | bit_mask;
      default:             edit_pat = held_r & ~bit_mask;
    endcase
  end

  // command decode and next state
  always_comb begin
    held_nxt       = held_r;
    mode_nxt       = mode_r;
    pending_nxt    = pending_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    run_tag_nxt    = run_tag_r;
    last_tag_nxt   = last_tag_r;
    last_rand_nxt  = last_rand_r;
    saved_mode_nxt = saved_mode_r;
    saved_pat_nxt  = saved_pat_r;
    lfsr_nxt       = lfsr_r;
    head_act_nxt   = head_act_r;
    last_end_nxt   = last_end_r;
    wr_en          = 1'b0;
    wr_addr        = tail_slot;
    wr_data        = new_act;
    emit           = 1'b0;
    emit_pat       = held_r;
    status         = lpas_pkg::ST_OK;

    unique case (op)
      lpas_pkg::OP_TICK: begin
        if (mode_r == lpas_pkg::MODE_FIXED ||
            (mode_r == lpas_pkg::MODE_ACTION && cnt_r == '0)) begin
          emit        = force_req || pending_r;
          pending_nxt = 1'b0;
        end else if (mode_r == lpas_pkg::MODE_ACTION) begin
          if (time_ms < head_act_r.end_ms) begin
            if (head_act_r.tag != run_tag_r) begin
              run_tag_nxt = head_act_r.tag;
              emit        = 1'b1;
              emit_pat    = head_act_r.pattern;
            end
          end else if (head_act_r.end_ms < time_ms) begin
            // head expired: move to the prefetched next entry
            head_nxt = head_inc;
            cnt_nxt  = cnt_r - 1'b1;
            if (cnt_r > CW'(1)) begin
              head_act_nxt = next_act_r;
              run_tag_nxt  = next_act_r.tag;
              emit         = 1'b1;
              emit_pat     = next_act_r.pattern;
            end
          end
        end else if (mode_r == lpas_pkg::MODE_RANDOM) begin
          if (elapsed > {16'd0, interval_r}) begin
            lfsr_nxt      = lfsr_b;
            emit          = 1'b1;
            emit_pat      = {lfsr_b[7:0], lfsr_a[7:0]};
            last_rand_nxt = time_ms;
          end
        end
      end
      lpas_pkg::OP_SET, lpas_pkg::OP_BIT_ON, lpas_pkg::OP_BIT_OFF: begin
        head_nxt    = '0;
        cnt_nxt     = '0;
        mode_nxt    = lpas_pkg::MODE_FIXED;
        pending_nxt = (edit_pat != held_r);
        held_nxt    = edit_pat;
      end
      lpas_pkg::OP_CLEAR: begin
        held_nxt    = '0;
        pending_nxt = 1'b1;
      end
      lpas_pkg::OP_APPEND: begin
        last_tag_nxt = tag_inc;
        mode_nxt     = lpas_pkg::MODE_ACTION;
        if (cnt_r == '0) begin
          wr_en        = 1'b1;
          wr_addr      = head_r;
          head_act_nxt = new_act;
          cnt_nxt      = CW'(1);
          last_end_nxt = end_ms;
          emit         = 1'b1;
          emit_pat     = in_pat;
        end else if (cnt_r >= DEPTH_C) begin
          status = lpas_pkg::ST_FULL;
        end else if (last_end_r >= end_ms) begin
          status = lpas_pkg::ST_ORDER;
        end else begin
          wr_en        = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          last_end_nxt = end_ms;
        end
      end
      lpas_pkg::OP_RAND_ON: begin
        head_nxt       = '0;
        cnt_nxt        = '0;
        saved_mode_nxt = mode_r;
        saved_pat_nxt  = held_r;
        mode_nxt       = lpas_pkg::MODE_RANDOM;
      end
      default: begin
        head_nxt = '0;
        cnt_nxt  = '0;
        if (mode_r == lpas_pkg::MODE_RANDOM) begin
          mode_nxt    = saved_mode_r;
          held_nxt    = saved_pat_r;
          pending_nxt = 1'b1;
        end
      end
    endcase
  end

  // read address follows the head that will be current next cycle
  assign rd_addr = in_fire ? ((head_nxt == LAST_SLOT) ? '0 : head_nxt + 1'b1) : head_inc;

  // action memory: one write, one registered read with write bypass
  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      act_mem[wr_addr] <= wr_data;
    end
    if (in_fire && wr_en && wr_addr == rd_addr) begin
      next_act_r <= wr_data;
    end else begin
      next_act_r <= act_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= lpas_pkg::RAND_INTERVAL_RST;
      held_r       <= '0;
      mode_r       <= lpas_pkg::MODE_FIXED;
      pending_r    <= 1'b0;
      head_r       <= '0;
      cnt_r        <= '0;
      run_tag_r    <= lpas_pkg::TAG_IDLE;
      last_tag_r   <= '0;
      last_rand_r  <= '0;
      saved_mode_r <= lpas_pkg::MODE_FIXED;
      saved_pat_r  <= '0;
      lfsr_r       <= lpas_pkg::LFSR_SEED;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        interval_r <= cfg_data;
      end
      if (in_fire) begin
        held_r       <= held_nxt;
        mode_r       <= mode_nxt;
        pending_r    <= pending_nxt;
        head_r       <= head_nxt;
        cnt_r        <= cnt_nxt;
        run_tag_r    <= run_tag_nxt;
        last_tag_r   <= last_tag_nxt;
        last_rand_r  <= last_rand_nxt;
        saved_mode_r <= saved_mode_nxt;
        saved_pat_r  <= saved_pat_nxt;
        lfsr_r       <= lfsr_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // payload registers: head cache, last queued end and the result word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      head_act_r   <= head_act_nxt;
      last_end_r   <= last_end_nxt;
      out_data_r   <= {5'd0, status, held_nxt[7:0],
                       emit ? emit_pat[15:8] : 8'd0,
                       emit ? emit_pat[7:0]  : 8'd0,
                       emit};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("action count above queue depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LAST_SLOT)
    else $error("queue head out of range");

  a_queue_mode: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> mode_r == lpas_pkg::MODE_ACTION)
    else $error("actions queued outside action mode");

  a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_tag_r < lpas_pkg::TAG_MODULO)
    else $error("tag out of range");

endmodule

// ===== bench/lpas_drive_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpas_drive_check: result checker for the LED pattern action sequencer
// Watches the command, configuration and result channels. It keeps its own
// copy of the sequencer state, works out the result word of every accepted
// command word, and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module lpas_drive_check #(
  parameter int unsigned DEPTH = lpas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // [31:0] time_ms, [32] force_req, [40:33] byte_low, [48:41] byte_high,
  // [52:49] bit_index, [84:53] end_ms, [87:85] zero
  input  logic [87:0] in_tdata,
  // [2:0] op
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [0] drive_valid, [8:1] drive_low, [16:9] drive_high, [24:17] held_low,
  // [26:25] append_status, [31:27] zero
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          words_pending,
  output int          mismatch_count
);

  // One result word, drive_valid in the lowest bit
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] held_low;
    logic [7:0] drv_high;
    logic [7:0] drv_low;
    logic       drv_valid;
  } drive_word_t;

  // Sequencer state as predicted
  logic [15:0] interval_ms;
  logic [15:0] held_pat;
  logic [1:0]  mode;
  logic        pend_change;
  logic [31:0] act_end [DEPTH];
  logic [15:0] act_pat [DEPTH];
  logic [6:0]  act_tag [DEPTH];
  int unsigned q_head;
  int unsigned q_count;
  logic [6:0]  run_tag;
  logic [6:0]  last_tag;
  logic [31:0] last_rand_ms;
  logic [1:0]  saved_mode;
  logic [15:0] saved_pat;
  logic [15:0] lfsr;

  drive_word_t drive_queue [$];

  initial mismatch_count = 0;

  // Word that drives a pattern out
  function automatic drive_word_t drive_of(input logic [15:0] p);
    drive_word_t w;
    w = '0;
    w.drv_valid = 1'b1;
    w.drv_low   = p[7:0];
    w.drv_high  = p[15:8];
    return w;
  endfunction

  // Galois LFSR, right shift
  function automatic logic [15:0] lfsr_shift(input logic [15:0] v);
    return v[0] ? ({1'b0, v[15:1]} ^ lpas_pkg::LFSR_TAPS) : {1'b0, v[15:1]};
  endfunction

  task automatic reset_state();
    interval_ms  = lpas_pkg::RAND_INTERVAL_RST;
    held_pat     = '0;
    mode         = lpas_pkg::MODE_FIXED;
    pend_change  = 1'b0;
    q_head       = 0;
    q_count      = 0;
    run_tag      = lpas_pkg::TAG_IDLE;
    last_tag     = '0;
    last_rand_ms = '0;
    saved_mode   = lpas_pkg::MODE_FIXED;
    saved_pat    = '0;
    lfsr         = lpas_pkg::LFSR_SEED;
  endtask

  // Timed step of the current mode
  task automatic tick_sequencer(input logic [31:0] now, input logic frc,
                                output drive_word_t w);
    logic [7:0] lo;
    logic [7:0] hi;
    w = '0;
    if (mode == lpas_pkg::MODE_FIXED ||
        (mode == lpas_pkg::MODE_ACTION && q_count == 0)) begin
      if (frc || pend_change) w = drive_of(held_pat);
      pend_change = 1'b0;
    end else if (mode == lpas_pkg::MODE_ACTION) begin
      if (now < act_end[q_head]) begin
        if (act_tag[q_head] != run_tag) begin
          run_tag = act_tag[q_head];
          w = drive_of(act_pat[q_head]);
        end
      end else if (act_end[q_head] < now) begin
        // head has expired: drop it, start the next one
        q_head  = (q_head + 1) % DEPTH;
        q_count = q_count - 1;
        if (q_count != 0) begin
          run_tag = act_tag[q_head];
          w = drive_of(act_pat[q_head]);
        end
      end
    end else if (mode == lpas_pkg::MODE_RANDOM) begin
      if (now - last_rand_ms > {16'd0, interval_ms}) begin
        lfsr = lfsr_shift(lfsr);
        lo   = lfsr[7:0];
        lfsr = lfsr_shift(lfsr);
        hi   = lfsr[7:0];
        w    = drive_of({hi, lo});
        last_rand_ms = now;
      end
    end
  endtask

  // Queue a timed action
  task automatic append_action(input logic [15:0] pat, input logic [31:0] endt,
                               output drive_word_t w);
    int unsigned s;
    w = '0;
    last_tag = 7'((32'(last_tag) + 1) % 32'(lpas_pkg::TAG_MODULO));
    mode     = lpas_pkg::MODE_ACTION;
    if (q_count == 0) begin
      act_end[q_head] = endt;
      act_pat[q_head] = pat;
      act_tag[q_head] = last_tag;
      q_count = 1;
      w = drive_of(pat);
    end else if (q_count >= DEPTH) begin
      w.status = lpas_pkg::ST_FULL;
    end else if (act_end[(q_head + q_count - 1) % DEPTH] >= endt) begin
      w.status = lpas_pkg::ST_ORDER;
    end else begin
      s = (q_head + q_count) % DEPTH;
      act_end[s] = endt;
      act_pat[s] = pat;
      act_tag[s] = last_tag;
      q_count = q_count + 1;
    end
  endtask

  // Result word of one command word
  task automatic advance_sequencer(input logic [2:0] op, input logic [87:0] d,
                                   output drive_word_t w);
    logic [31:0] now;
    logic [15:0] pat;
    logic [15:0] bmask;
    logic [15:0] nv;
    now   = d[31:0];
    pat   = {d[48:41], d[40:33]};
    bmask = 16'd1 << d[52:49];
    w     = '0;
    case (op)
      lpas_pkg::OP_TICK: tick_sequencer(now, d[32], w);
      lpas_pkg::OP_SET, lpas_pkg::OP_BIT_ON, lpas_pkg::OP_BIT_OFF: begin
        q_head  = 0;
        q_count = 0;
        mode    = lpas_pkg::MODE_FIXED;
        if (op == lpas_pkg::OP_SET) nv = pat;
        else if (op == lpas_pkg::OP_BIT_ON) nv = held_pat | bmask;
        else nv = held_pat & ~bmask;
        pend_change = (nv != held_pat);
        held_pat    = nv;
      end
      lpas_pkg::OP_CLEAR: begin
        held_pat    = '0;
        pend_change = 1'b1;
      end
      lpas_pkg::OP_APPEND: append_action(pat, d[84:53], w);
      lpas_pkg::OP_RAND_ON: begin
        q_head     = 0;
        q_count    = 0;
        saved_mode = mode;
        saved_pat  = held_pat;
        mode       = lpas_pkg::MODE_RANDOM;
      end
      default: begin
        q_head  = 0;
        q_count = 0;
        if (mode == lpas_pkg::MODE_RANDOM) begin
          mode        = saved_mode;
          held_pat    = saved_pat;
          pend_change = 1'b1;
        end
      end
    endcase
    w.held_low = held_pat[7:0];
  endtask

  // Result words first: they belong to earlier command words
  always @(posedge clk) begin
    drive_word_t w;
    drive_word_t got;
    if (!rst_n) begin
      reset_state();
      drive_queue.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = drive_word_t'(out_tdata[26:0]);
        if (drive_queue.size() == 0) begin
          $error("result word 0x%08h with no command word pending", out_tdata);
          mismatch_count++;
        end else begin
          w = drive_queue.pop_front();
          if (got.drv_valid !== w.drv_valid) begin
            $error("drive_valid: expected %0d, got %0d", w.drv_valid, got.drv_valid);
            mismatch_count++;
          end
          if (got.drv_low !== w.drv_low) begin
            $error("drive_low: expected 0x%02h, got 0x%02h", w.drv_low, got.drv_low);
            mismatch_count++;
          end
          if (got.drv_high !== w.drv_high) begin
            $error("drive_high: expected 0x%02h, got 0x%02h", w.drv_high, got.drv_high);
            mismatch_count++;
          end
          if (got.held_low !== w.held_low) begin
            $error("held_low: expected 0x%02h, got 0x%02h", w.held_low, got.held_low);
            mismatch_count++;
          end
          if (got.status !== w.status) begin
            $error("append_status: expected %0d, got %0d", w.status, got.status);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) interval_ms = cfg_data;
      if (in_tvalid && in_tready) begin
        advance_sequencer(in_tuser, in_tdata, w);
        drive_queue.push_back(w);
      end
    end
    words_pending <= drive_queue.size();
  end

endmodule

// ===== bench/tb_led_pattern_action_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_pattern_action_sequencer: testbench of the LED pattern sequencer
// Directed words for each command and corner case, then random sequences of
// action runs, random-mode runs, pattern edits and noise over several random
// interval settings and idle/stall mixes. Results are checked by
// lpas_drive_check.
// ----------------------------------------------------------------------------
module tb_led_pattern_action_sequencer;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 275;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [2:0]  in_tuser = lpas_pkg::OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int          words_pending;
  int          mismatch_count;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  logic [31:0] now_ms = 32'd1000;
  logic [15:0] cur_interval = lpas_pkg::RAND_INTERVAL_RST;

  always #5 clk = ~clk;

  led_pattern_action_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lpas_drive_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .words_pending (words_pending),
    .mismatch_count(mismatch_count)
  );

  // Result side: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("led_pattern_action_sequencer verification failed");
      $finish;
    end
  end

  // Offer one command word, with random idle cycles ahead of it
  task automatic send_word(input logic [2:0] op, input logic [31:0] tm,
                           input logic frc, input logic [7:0] lo,
                           input logic [7:0] hi, input logic [3:0] bidx,
                           input logic [31:0] endt);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, endt, bidx, hi, lo, frc, tm};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_tick(input logic [31:0] tm, input logic frc);
    send_word(lpas_pkg::OP_TICK, tm, frc, 8'($urandom), 8'($urandom), 4'($urandom),
              $urandom);
  endtask

  task automatic send_append(input logic [31:0] endt);
    send_word(lpas_pkg::OP_APPEND, $urandom, 1'($urandom), 8'($urandom), 8'($urandom),
              4'($urandom), endt);
  endtask

  // Wait until every result word is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_interval = v;
  endtask

  // Action run: ordered appends, some out of order or overfilling,
  // then ticks walking time across the end times
  task automatic run_actions();
    int k;
    int m;
    logic [31:0] endt;
    k = $urandom_range(1, 10);
    endt = now_ms + $urandom_range(1, 60);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_append(endt - $urandom_range(0, 20));
      end else begin
        endt = endt + $urandom_range(1, 40);
        send_append(endt);
      end
      if ($urandom_range(0, 1) == 1) begin
        now_ms = now_ms + $urandom_range(0, 15);
        send_tick(now_ms, 1'($urandom));
      end
    end
    m = $urandom_range(3, 30);
    for (int j = 0; j < m; j++) begin
      now_ms = now_ms + $urandom_range(0, 20);
      send_tick(now_ms, 1'($urandom));
    end
  endtask

  // Random-mode run
  task automatic run_random_mode();
    int k;
    send_word(lpas_pkg::OP_RAND_ON, $urandom, 1'($urandom), 8'($urandom), 8'($urandom),
              4'($urandom), $urandom);
    k = $urandom_range(2, 12);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(lpas_pkg::OP_RAND_ON, $urandom, 1'($urandom), 8'($urandom),
                  8'($urandom), 4'($urandom), $urandom);
      end else begin
        now_ms = now_ms + $urandom_range(0, 2 * cur_interval + 2);
        send_tick(now_ms, 1'($urandom));
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      send_word(lpas_pkg::OP_RAND_OFF, $urandom, 1'($urandom), 8'($urandom),
                8'($urandom), 4'($urandom), $urandom);
    end
  endtask

  // Pattern edits with ticks
  task automatic run_edits();
    int k;
    logic [2:0] op;
    k = $urandom_range(2, 10);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(0, 4))
        0: op = lpas_pkg::OP_SET;
        1: op = lpas_pkg::OP_BIT_ON;
        2: op = lpas_pkg::OP_BIT_OFF;
        3: op = lpas_pkg::OP_CLEAR;
        default: op = lpas_pkg::OP_TICK;
      endcase
      now_ms = now_ms + $urandom_range(0, 10);
      send_word(op, now_ms, 1'($urandom), 8'($urandom), 8'($urandom),
                4'($urandom), $urandom);
    end
  endtask

  task automatic run_random_words(input int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: run_actions();
        4, 5: run_random_mode();
        6, 7: run_edits();
        default: begin
          // noise: any command, any field value
          repeat ($urandom_range(1, 4))
            send_word(3'($urandom), $urandom, 1'($urandom), 8'($urandom),
                      8'($urandom), 4'($urandom), $urandom);
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fixed mode, forced and changed re-emission
    send_word(lpas_pkg::OP_TICK, 32'd0, 1'b1, 8'h00, 8'h00, 4'd0, 32'd0);
    send_word(lpas_pkg::OP_SET, 32'd0, 1'b0, 8'hFF, 8'h00, 4'd0, 32'd0);
    send_word(lpas_pkg::OP_TICK, 32'd5, 1'b0, 8'h00, 8'h00, 4'd0, 32'd0);
    send_word(lpas_pkg::OP_SET, 32'd0, 1'b0, 8'hFF, 8'h00, 4'd0, 32'd0);
    send_word(lpas_pkg::OP_TICK, 32'd6, 1'b0, 8'h00, 8'h00, 4'd0, 32'd0);
    send_word(lpas_pkg::OP_BIT_ON, 32'd0, 1'b0, 8'h00, 8'h00, 4'd15, 32'd0);
    send_word(lpas_pkg::OP_BIT_OFF, 32'd0, 1'b0, 8'h00, 8'h00, 4'd0, 32'd0);
    send_word(lpas_pkg::OP_CLEAR, 32'd0, 1'b0, 8'h00, 8'h00, 4'd0, 32'd0);
    // Action queue: append to empty, repeat emit, order and full rejects
    send_word(lpas_pkg::OP_APPEND, 32'd0, 1'b0, 8'h12, 8'h34, 4'd0, 32'd100);
    send_tick(32'd50, 1'b0);
    send_tick(32'd60, 1'b0);
    send_word(lpas_pkg::OP_APPEND, 32'd0, 1'b0, 8'h56, 8'h78, 4'd0, 32'd100);
    for (int i = 1; i < 7; i++)
      send_word(lpas_pkg::OP_APPEND, 32'd0, 1'b0, 8'(i), 8'hA0, 4'd0, 32'(100 + 50 * i));
    send_word(lpas_pkg::OP_APPEND, 32'd0, 1'b0, 8'hFF, 8'hFF, 4'd0, 32'hFFFF_FFFF);
    send_word(lpas_pkg::OP_APPEND, 32'd0, 1'b0, 8'h00, 8'h00, 4'd0, 32'hFFFF_FFFF);
    // head exactly at its end time, then past it
    send_tick(32'd100, 1'b0);
    send_tick(32'd101, 1'b0);
    // Random mode: save, repeated on, restore, off outside random mode
    send_word(lpas_pkg::OP_RAND_ON, 32'd0, 1'b0, 8'h00, 8'h00, 4'd0, 32'd0);
    send_tick(32'hFFFF_FFFF, 1'b0);
    send_tick(32'hFFFF_FF00, 1'b0);
    send_word(lpas_pkg::OP_RAND_ON, 32'd0, 1'b0, 8'h00, 8'h00, 4'd0, 32'd0);
    send_word(lpas_pkg::OP_RAND_OFF, 32'd0, 1'b0, 8'h00, 8'h00, 4'd0, 32'd0);
    send_word(lpas_pkg::OP_SET, 32'd0, 1'b0, 8'hFF, 8'hFF, 4'd0, 32'd0);
    send_word(lpas_pkg::OP_RAND_OFF, 32'd0, 1'b0, 8'h00, 8'h00, 4'd0, 32'd0);
    drain();

    // Random phases over interval settings and idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  write_interval(16'd0); end
        1: begin idle_pct = 81; stall_pct = 0;  write_interval(16'hFFFF); end
        2: begin idle_pct = 0;  stall_pct = 81; write_interval(16'($urandom_range(1, 2000))); end
        default: begin idle_pct = 26; stall_pct = 26; write_interval(16'd1); end
      endcase
      // long receiver hold-off while words keep coming
      if (ph == 0) hold_left = 300;
      run_random_words(PHASE_WORDS);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("led_pattern_action_sequencer verification clean");
    end else begin
      $display("led_pattern_action_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== led_pattern_action_sequencer.f =====
rtl/core/lpas_pkg.sv
rtl/core/led_pattern_action_sequencer.sv
bench/lpas_drive_check.sv
bench/tb_led_pattern_action_sequencer.sv
